>>> src/kqt_pkg.sv
package kqt_pkg;

  localparam int CMD_BITS       = 2;
  localparam int KEY_IN_BITS    = 16;
  localparam int AMOUNT_BITS    = 32;
  localparam int COUNT_OUT_BITS = 32;
  localparam int TOTAL_OUT_BITS = 38;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SET    = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

endpackage

>>> src/keyed_quantity_table.sv
// An accepted input word passes through stage 1 and stage 2 before its result word is registered.
// Throughput: one word per cycle while out_ready allows; a command on the same key as the one
// ahead of it takes the forwarded count, so same-key words back to back cause no stall.
// Reset clears the valid bits, running total, free-slot stack and fill count.
// Key and count storage is not cleared; no clearing pass is needed.
module keyed_quantity_table #(
  parameter int ENTRIES    = 64,
  parameter int KEY_BITS   = 16,
  parameter int COUNT_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [kqt_pkg::CMD_BITS-1:0]          cmd,
  input  logic [kqt_pkg::KEY_IN_BITS-1:0]       item_key,
  input  logic [kqt_pkg::AMOUNT_BITS-1:0]       amount,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [kqt_pkg::COUNT_OUT_BITS-1:0]    key_count,
  output logic                                  has_enough,
  output logic [kqt_pkg::TOTAL_OUT_BITS-1:0]    total_quantity,
  output logic                                  table_full,
  output logic                                  set_empty
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int TW = COUNT_BITS + $clog2(ENTRIES);
  localparam int AW = (COUNT_BITS > kqt_pkg::AMOUNT_BITS) ? COUNT_BITS : kqt_pkg::AMOUNT_BITS;
  localparam int QW = (COUNT_BITS > kqt_pkg::COUNT_OUT_BITS) ? COUNT_BITS
                                                             : kqt_pkg::COUNT_OUT_BITS;
  localparam int OW = (TW > kqt_pkg::TOTAL_OUT_BITS) ? TW : kqt_pkg::TOTAL_OUT_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // table state
  logic [KEY_BITS-1:0]   entry_keys [ENTRIES];
  logic [COUNT_BITS-1:0] entry_counts [ENTRIES];
  logic [ENTRIES-1:0]    entry_valid;
  logic [TW-1:0]         running_total;
  logic [CW-1:0]         valid_cnt;
  logic [CW-1:0]         fill;
  logic [CW-1:0]         sp;
  logic [IW-1:0]         free_stack [ENTRIES];
  logic [IW-1:0]         top;

  // stage 1
  logic                    s1_valid;
  kqt_pkg::cmd_t           s1_cmd;
  logic [KEY_BITS-1:0]     s1_key;
  logic [kqt_pkg::AMOUNT_BITS-1:0] s1_amt;
  logic                    m_hit;
  logic [IW-1:0]           m_idx;

  // stage 2
  logic                    s2_valid;
  kqt_pkg::cmd_t           s2_cmd;
  logic [KEY_BITS-1:0]     s2_key;
  logic [kqt_pkg::AMOUNT_BITS-1:0] s2_amt;
  logic                    s2_hit;
  logic [IW-1:0]           s2_idx;
  logic                    s2_fwd;
  logic [COUNT_BITS-1:0]   s2_fwd_cnt;
  logic [COUNT_BITS-1:0]   rd_cnt;

  logic s1_move;
  logic s2_move;
  logic fwd;

  logic [COUNT_BITS-1:0] cur;
  logic [AW-1:0]         amt_w;
  logic [COUNT_BITS-1:0] nv;
  logic                  amt_nz;
  logic                  avail;
  logic [IW-1:0]         alloc_idx;
  logic                  need;
  logic                  claim;
  logic                  full;
  logic                  live;
  logic [IW-1:0]         slot;
  logic [COUNT_BITS-1:0] room;
  logic [COUNT_BITS-1:0] add_take;
  logic [COUNT_BITS-1:0] rem_take;
  logic [COUNT_BITS-1:0] cnt_after;
  logic [COUNT_BITS-1:0] add_term;
  logic [COUNT_BITS-1:0] sub_term;
  logic                  valid_after;
  logic                  freed;
  logic                  wr_count;
  logic [TW-1:0]         running_total_next;
  logic [CW-1:0]         valid_cnt_next;
  logic [CW-1:0]         sp_m2;
  logic [QW-1:0]         cnt_ext;
  logic [OW-1:0]         total_ext;

  assign s2_move  = s2_valid && (!out_valid || out_ready);
  assign s1_move  = s1_valid && (!s2_valid || s2_move);
  assign in_ready = !s1_valid || s1_move;
  assign fwd      = s2_move && (s2_key == s1_key);

  kqt_match #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_match (
    .entry_keys  (entry_keys),
    .entry_valid (entry_valid),
    .key         (s1_key),
    .hit         (m_hit),
    .idx         (m_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd <= kqt_pkg::cmd_t'(cmd);
      s1_key <= KEY_BITS'(item_key);
      s1_amt <= amount;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_move) begin
      s2_valid <= 1'b1;
    end else if (s2_move) begin
      s2_valid <= 1'b0;
    end
  end

  // take the word ahead's result when it commits on the same key
  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_cmd     <= s1_cmd;
      s2_key     <= s1_key;
      s2_amt     <= s1_amt;
      s2_hit     <= fwd ? valid_after : m_hit;
      s2_idx     <= fwd ? slot : m_idx;
      s2_fwd     <= fwd;
      s2_fwd_cnt <= cnt_after;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move && wr_count) begin
      entry_counts[slot] <= cnt_after;
    end
    if (s1_move) begin
      rd_cnt <= entry_counts[m_idx];
    end
  end

  assign cur       = s2_hit ? (s2_fwd ? s2_fwd_cnt : rd_cnt) : '0;
  assign amt_w     = AW'(s2_amt);
  assign nv        = (amt_w > AW'(COUNT_MAX)) ? COUNT_MAX : amt_w[COUNT_BITS-1:0];
  assign amt_nz    = (s2_amt != '0);
  assign avail     = (sp != '0) || (fill != CW'(ENTRIES));
  assign alloc_idx = (sp != '0) ? top : fill[IW-1:0];
  assign need      = !s2_hit && (((s2_cmd == kqt_pkg::CMD_ADD) && amt_nz) ||
                                 ((s2_cmd == kqt_pkg::CMD_SET) && (nv != '0)));
  assign claim     = need && avail;
  assign full      = need && !avail;
  assign live      = s2_hit || claim;
  assign slot      = s2_hit ? s2_idx : alloc_idx;
  assign room      = COUNT_MAX - cur;
  assign add_take  = (amt_w < AW'(room)) ? amt_w[COUNT_BITS-1:0] : room;
  assign rem_take  = (amt_w < AW'(cur)) ? amt_w[COUNT_BITS-1:0] : cur;

  always_comb begin
    cnt_after = cur;
    add_term  = '0;
    sub_term  = '0;
    wr_count  = 1'b0;
    case (s2_cmd)
      kqt_pkg::CMD_ADD: begin
        if (live) begin
          cnt_after = cur + add_take;
          add_term  = add_take;
          wr_count  = 1'b1;
        end
      end
      kqt_pkg::CMD_REMOVE: begin
        cnt_after = cur - rem_take;
        sub_term  = rem_take;
        wr_count  = live;
      end
      kqt_pkg::CMD_SET: begin
        if (live) begin
          cnt_after = nv;
          add_term  = nv;
          sub_term  = cur;
          wr_count  = 1'b1;
        end
      end
      default: begin
        cnt_after = cur;
      end
    endcase
  end

  assign valid_after        = live && (cnt_after != '0);
  assign freed              = s2_hit && (cnt_after == '0);
  assign running_total_next = running_total + TW'(add_term) - TW'(sub_term);
  assign valid_cnt_next     = valid_cnt + CW'(claim) - CW'(freed);
  assign sp_m2              = sp - CW'(2);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid   <= '0;
      running_total <= '0;
      valid_cnt     <= '0;
      fill          <= '0;
      sp            <= '0;
    end else if (s2_move) begin
      running_total <= running_total_next;
      valid_cnt     <= valid_cnt_next;
      if (claim) begin
        entry_valid[slot] <= 1'b1;
        if (sp != '0) begin
          sp <= sp - CW'(1);
        end else begin
          fill <= fill + CW'(1);
        end
      end
      if (freed) begin
        entry_valid[s2_idx] <= 1'b0;
        sp <= sp + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move && claim) begin
      entry_keys[slot] <= s2_key;
    end
  end

  // free-slot stack; top holds the entry at sp-1
  always_ff @(posedge clk) begin
    if (s2_move && freed) begin
      free_stack[sp[IW-1:0]] <= s2_idx;
      top <= s2_idx;
    end else if (s2_move && claim && (sp != '0)) begin
      top <= free_stack[sp_m2[IW-1:0]];
    end
  end

  assign cnt_ext   = QW'(cnt_after);
  assign total_ext = OW'(running_total_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      key_count      <= (cnt_ext > QW'({kqt_pkg::COUNT_OUT_BITS{1'b1}})) ? '1
                        : cnt_ext[kqt_pkg::COUNT_OUT_BITS-1:0];
      has_enough     <= !amt_nz || (AW'(cnt_after) >= amt_w);
      total_quantity <= (total_ext > OW'({kqt_pkg::TOTAL_OUT_BITS{1'b1}})) ? '1
                        : total_ext[kqt_pkg::TOTAL_OUT_BITS-1:0];
      table_full     <= full;
      set_empty      <= (valid_cnt_next == '0);
    end
  end

  a_slot_balance: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, sp} + {1'b0, valid_cnt}) == {1'b0, fill})
    else $error("free stack and live entries do not add up to fill count");

  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    $countones(entry_valid) == valid_cnt)
    else $error("live entry count out of step with valid bits");

  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> !set_empty)
    else $error("table reported full and empty together");

  a_claim_free: assert property (@(posedge clk) disable iff (rst)
    s2_move && claim |-> !entry_valid[slot])
    else $error("allocated a slot that is still live");

endmodule

>>> src/kqt_match.sv
module kqt_match #(
  parameter int ENTRIES  = 64,
  parameter int KEY_BITS = 16
) (
  input  logic [KEY_BITS-1:0]         entry_keys [ENTRIES],
  input  logic [ENTRIES-1:0]          entry_valid,
  input  logic [KEY_BITS-1:0]         key,
  output logic                        hit,
  output logic [$clog2(ENTRIES)-1:0]  idx
);

  localparam int IW = $clog2(ENTRIES);

  logic [ENTRIES-1:0] match;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = entry_valid[i] && (entry_keys[i] == key);
    end
  end

  // keys of live entries are unique, so at most one bit of match is set
  always_comb begin
    idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      idx = idx | (match[i] ? IW'(i) : IW'(0));
    end
  end

  assign hit = |match;

endmodule

>>> tb/stock_checker.sv
module stock_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [kqt_pkg::CMD_BITS-1:0]       cmd,
  input  logic [kqt_pkg::KEY_IN_BITS-1:0]    item_key,
  input  logic [kqt_pkg::AMOUNT_BITS-1:0]    amount,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [kqt_pkg::COUNT_OUT_BITS-1:0] key_count,
  input  logic                               has_enough,
  input  logic [kqt_pkg::TOTAL_OUT_BITS-1:0] total_quantity,
  input  logic                               table_full,
  input  logic                               set_empty,
  output int                                 failures,
  output int                                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 64;

  typedef struct packed {
    logic [kqt_pkg::KEY_IN_BITS-1:0]    key;
    logic [kqt_pkg::COUNT_OUT_BITS-1:0] key_count;
    logic                               has_enough;
    logic [kqt_pkg::TOTAL_OUT_BITS-1:0] total;
    logic                               full;
    logic                               empty;
  } outcome_t;

  logic [kqt_pkg::COUNT_OUT_BITS-1:0] stock [bit [kqt_pkg::KEY_IN_BITS-1:0]];
  logic [kqt_pkg::TOTAL_OUT_BITS-1:0] tally;
  outcome_t                           owed_results[$];

  initial begin
    failures = 0;
    pending  = 0;
    tally    = '0;
  end

  function automatic outcome_t apply_command(input kqt_pkg::cmd_t op,
                                             input bit [kqt_pkg::KEY_IN_BITS-1:0] k,
                                             input logic [kqt_pkg::AMOUNT_BITS-1:0] amt);
    outcome_t                           r;
    logic [kqt_pkg::COUNT_OUT_BITS-1:0] held;
    logic [kqt_pkg::COUNT_OUT_BITS-1:0] room;
    logic [kqt_pkg::COUNT_OUT_BITS-1:0] take;
    bit                                 present;
    r       = '0;
    present = stock.exists(k);
    held    = present ? stock[k] : '0;
    case (op)
      kqt_pkg::CMD_ADD: begin
        if (amt != 0) begin
          if (!present && stock.num() >= SLOTS) begin
            r.full = 1'b1;
          end else begin
            room     = {kqt_pkg::COUNT_OUT_BITS{1'b1}} - held;
            take     = (amt < room) ? amt : room;
            stock[k] = held + take;
            tally    = tally + take;
          end
        end
      end
      kqt_pkg::CMD_REMOVE: begin
        if (amt != 0 && present) begin
          take  = (amt < held) ? amt : held;
          tally = tally - take;
          if (take == held) begin
            stock.delete(k);
          end else begin
            stock[k] = held - take;
          end
        end
      end
      kqt_pkg::CMD_SET: begin
        if (!present && amt != 0 && stock.num() >= SLOTS) begin
          r.full = 1'b1;
        end else if (present || amt != 0) begin
          tally = tally - held + amt;
          if (amt == 0) begin
            stock.delete(k);
          end else begin
            stock[k] = amt;
          end
        end
      end
      kqt_pkg::CMD_QUERY: begin
      end
      default: begin
      end
    endcase
    held         = stock.exists(k) ? stock[k] : '0;
    r.key        = k;
    r.key_count  = held;
    r.has_enough = (amt == 0) || (held >= amt);
    r.total      = tally;
    r.empty      = (stock.num() == 0);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    outcome_t want;
    if (rst) begin
      stock.delete();
      tally = '0;
      owed_results.delete();
    end else begin
      if (in_valid && in_ready) begin
        owed_results.push_back(apply_command(kqt_pkg::cmd_t'(cmd), item_key, amount));
      end
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          failures++;
          if (failures <= 10) begin
            $display("%0t: result word with no command outstanding", $realtime);
          end
        end else begin
          want = owed_results.pop_front();
          if (key_count !== want.key_count || has_enough !== want.has_enough ||
              total_quantity !== want.total || table_full !== want.full ||
              set_empty !== want.empty) begin
            failures++;
            if (failures <= 10) begin
              $display("%0t: key %h expected count %h enough %b total %h full %b empty %b",
                       $realtime, want.key, want.key_count, want.has_enough, want.total,
                       want.full, want.empty);
              $display("%0t: key %h got      count %h enough %b total %h full %b empty %b",
                       $realtime, want.key, key_count, has_enough, total_quantity,
                       table_full, set_empty);
            end
          end
        end
      end
    end
    pending = owed_results.size();
  end

endmodule

>>> tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORD_TARGET = 2000;
  localparam int IDLE_LIMIT  = 1000;

  logic                               clk;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic [kqt_pkg::CMD_BITS-1:0]       cmd = kqt_pkg::CMD_ADD;
  logic [kqt_pkg::KEY_IN_BITS-1:0]    item_key = '0;
  logic [kqt_pkg::AMOUNT_BITS-1:0]    amount = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic [kqt_pkg::COUNT_OUT_BITS-1:0] key_count;
  logic                               has_enough;
  logic [kqt_pkg::TOTAL_OUT_BITS-1:0] total_quantity;
  logic                               table_full;
  logic                               set_empty;
  int                                 failures;
  int                                 pending;
  int                                 words_sent = 0;
  bit                                 send_burst = 1'b0;
  bit                                 take_burst = 1'b0;
  bit                                 touched [bit [kqt_pkg::KEY_IN_BITS-1:0]];

  keyed_quantity_table dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .item_key       (item_key),
    .amount         (amount),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .key_count      (key_count),
    .has_enough     (has_enough),
    .total_quantity (total_quantity),
    .table_full     (table_full),
    .set_empty      (set_empty)
  );

  stock_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .item_key       (item_key),
    .amount         (amount),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .key_count      (key_count),
    .has_enough     (has_enough),
    .total_quantity (total_quantity),
    .table_full     (table_full),
    .set_empty      (set_empty),
    .failures       (failures),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [kqt_pkg::AMOUNT_BITS-1:0] pick_amount();
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2, 3: return $urandom_range(1, 16);
      4:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
      5:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input kqt_pkg::cmd_t op,
                           input logic [kqt_pkg::KEY_IN_BITS-1:0] k,
                           input logic [kqt_pkg::AMOUNT_BITS-1:0] amt);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 14);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= op;
    item_key <= k;
    amount   <= amt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if ((op == kqt_pkg::CMD_ADD || op == kqt_pkg::CMD_SET) && amt != 0) touched[k] = 1'b1;
    words_sent++;
  endtask

  initial begin
    int                              mode;
    int                              seg_len;
    int                              pool;
    int                              base;
    int                              pick;
    logic [kqt_pkg::KEY_IN_BITS-1:0] k;
    kqt_pkg::cmd_t                   op;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_word(kqt_pkg::CMD_QUERY,  16'h0000, 32'h0000_0000);
    send_word(kqt_pkg::CMD_QUERY,  16'hFFFF, 32'h0000_0001);
    send_word(kqt_pkg::CMD_ADD,    16'h0001, 32'h0000_0000);
    send_word(kqt_pkg::CMD_REMOVE, 16'h0001, 32'h0000_0005);
    send_word(kqt_pkg::CMD_SET,    16'h0001, 32'h0000_0000);
    send_word(kqt_pkg::CMD_ADD,    16'h0001, 32'hFFFF_FFFF);
    send_word(kqt_pkg::CMD_ADD,    16'h0001, 32'h0000_0001);
    send_word(kqt_pkg::CMD_QUERY,  16'h0001, 32'hFFFF_FFFF);
    send_word(kqt_pkg::CMD_ADD,    16'hFFFF, 32'h0000_0007);
    send_word(kqt_pkg::CMD_REMOVE, 16'hFFFF, 32'h0000_0064);
    send_word(kqt_pkg::CMD_SET,    16'h0002, 32'h0000_000C);
    send_word(kqt_pkg::CMD_QUERY,  16'h0002, 32'h0000_000D);
    send_word(kqt_pkg::CMD_SET,    16'h0002, 32'h0000_0000);
    send_word(kqt_pkg::CMD_REMOVE, 16'h0001, 32'h0000_0000);
    send_word(kqt_pkg::CMD_REMOVE, 16'h0001, 32'h0000_0001);
    send_word(kqt_pkg::CMD_QUERY,  16'h0001, 32'hFFFF_FFFF);
    send_word(kqt_pkg::CMD_SET,    16'h8000, 32'hFFFF_FFFF);
    send_word(kqt_pkg::CMD_ADD,    16'h8000, 32'hFFFF_FFFF);
    send_word(kqt_pkg::CMD_SET,    16'h0001, 32'h0000_0000);
    send_word(kqt_pkg::CMD_REMOVE, 16'h8000, 32'hFFFF_FFFF);
    send_word(kqt_pkg::CMD_QUERY,  16'h8000, 32'h0000_0000);
    touched.delete();

    while (words_sent < WORD_TARGET) begin
      mode       = $urandom_range(0, 3);
      seg_len    = $urandom_range(60, 160);
      send_burst = ($urandom_range(0, 3) == 0);
      pool       = (mode == 0) ? 4 : (mode == 1) ? 72 : 2;
      base       = $urandom_range(0, 65535 - pool);
      repeat (seg_len) begin
        k = (mode == 2) ? kqt_pkg::KEY_IN_BITS'($urandom)
                        : kqt_pkg::KEY_IN_BITS'(base + $urandom_range(0, pool - 1));
        case (mode)
          1: begin
            pick = $urandom_range(0, 19);
            op   = (pick < 9) ? kqt_pkg::CMD_ADD : (pick < 13) ? kqt_pkg::CMD_SET :
                   (pick < 17) ? kqt_pkg::CMD_REMOVE : kqt_pkg::CMD_QUERY;
          end
          3: op = ($urandom_range(0, 3) == 0) ? kqt_pkg::CMD_QUERY : kqt_pkg::CMD_ADD;
          default: op = kqt_pkg::cmd_t'($urandom_range(0, 3));
        endcase
        send_word(op, k, pick_amount());
      end
      // empty the table now and then so that fresh keys can be placed again
      if ($urandom_range(0, 1) == 0 || touched.num() > 120) begin
        foreach (touched[dk]) begin
          op = ($urandom_range(0, 1) == 0) ? kqt_pkg::CMD_SET : kqt_pkg::CMD_REMOVE;
          send_word(op, dk, (op == kqt_pkg::CMD_SET) ? '0 : {kqt_pkg::AMOUNT_BITS{1'b1}});
        end
        touched.delete();
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    int stall;
    int taken;
    taken = 0;
    while (rst) @(negedge clk);
    forever begin
      if (taken % 128 == 0) take_burst = ($urandom_range(0, 2) == 0);
      stall = take_burst ? 0 : $urandom_range(0, 14);
      // hold off for a long stretch once so the pipeline backs up
      if (taken == 400) stall = 300;
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Regression FAIL");
    $finish;
  end

endmodule
